@@ rtl/core/drho_pkg.sv @@
// package for the dickman rho evaluator
// types, controller states, base row table and saturating add
// no dependencies
package drho_pkg;

    localparam int CFG_W   = 5;
    localparam int WORD_W  = 64;
    localparam int FRAC_W  = 24;
    localparam int X_W     = 28;
    localparam int IP_W    = X_W - FRAC_W;
    localparam int DVSR_W  = 5;
    localparam int REM_W   = 5;
    localparam int CNT_W   = 6;
    localparam int BASE_N  = 32;

    localparam logic [WORD_W-1:0] ONE_MINUS_LN2 = 64'h4E8DE8082E308654;

    // row 0: 1-ln2, then floor(2^(64-i)/i) for i = 1..29, zero for i = 30 and 31
    localparam logic [WORD_W-1:0] ROW0 [BASE_N] = '{
        ONE_MINUS_LN2,
        (64'd1 << 63) / 64'd1,
        (64'd1 << 62) / 64'd2,
        (64'd1 << 61) / 64'd3,
        (64'd1 << 60) / 64'd4,
        (64'd1 << 59) / 64'd5,
        (64'd1 << 58) / 64'd6,
        (64'd1 << 57) / 64'd7,
        (64'd1 << 56) / 64'd8,
        (64'd1 << 55) / 64'd9,
        (64'd1 << 54) / 64'd10,
        (64'd1 << 53) / 64'd11,
        (64'd1 << 52) / 64'd12,
        (64'd1 << 51) / 64'd13,
        (64'd1 << 50) / 64'd14,
        (64'd1 << 49) / 64'd15,
        (64'd1 << 48) / 64'd16,
        (64'd1 << 47) / 64'd17,
        (64'd1 << 46) / 64'd18,
        (64'd1 << 45) / 64'd19,
        (64'd1 << 44) / 64'd20,
        (64'd1 << 43) / 64'd21,
        (64'd1 << 42) / 64'd22,
        (64'd1 << 41) / 64'd23,
        (64'd1 << 40) / 64'd24,
        (64'd1 << 39) / 64'd25,
        (64'd1 << 38) / 64'd26,
        (64'd1 << 37) / 64'd27,
        (64'd1 << 36) / 64'd28,
        (64'd1 << 35) / 64'd29,
        64'd0,
        64'd0
    };

    typedef enum logic [4:0] {
        S_IDLE,
        S_BROW,
        S_BJ,
        S_BRD,
        S_BWAIT,
        S_BDMS,
        S_BDMW,
        S_BDJS,
        S_BDJW,
        S_BWRJ,
        S_BHW,
        S_B0S,
        S_B0W,
        S_ERD,
        S_EW,
        S_EM1,
        S_EM2,
        S_EADD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? '1 : s[WORD_W-1:0];
    endfunction

endpackage

@@ rtl/core/dickman_rho_evaluator.sv @@
// evaluation runs a horner loop over n coefficients once the row is built, n the clamped count
// building a missing row takes roughly n^3/6 passes of the bit-serial divider
// one item at a time: in_stall stays high from accept until the result is loaded for output
// out-of-range x skips to S_DONE, status set; reset keeps row 0 only, from a constant table
// coefficient memory is not cleared, rows are rebuilt after a num_coeffs write
module dickman_rho_evaluator
    import drho_pkg::*;
#(
    parameter int MAX_LINES  = 8,
    parameter int MAX_COEFFS = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [X_W-1:0]    x_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] rho_value,
    output logic              status
);

    localparam int ROW_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int IDX_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int RB_W  = $clog2(MAX_LINES + 1);
    localparam int DEPTH = MAX_LINES << IDX_W;
    localparam int D_W   = FRAC_W + 1;
    localparam int P_W   = 32 + D_W;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  num_coeffs_reg;
    logic [RB_W-1:0]   rows_built_reg;
    logic [ROW_W-1:0]  row_reg, brow_reg;
    logic [IDX_W-1:0]  j_reg, k_reg, p_reg, i_reg;
    logic [WORD_W-1:0] t_reg, c_reg, head_reg, acc_reg;
    logic [D_W-1:0]    d_reg;
    logic [P_W-1:0]    phi_reg, plo_reg;
    logic              err_reg;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] rho_reg;
    logic              status_reg;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg, rd_const_reg;
    logic              rd_base_reg;
    logic [WORD_W-1:0] rd_val;

    logic              rd_en, wr_en;
    logic [ROW_W-1:0]  rd_row;
    logic [IDX_W-1:0]  rd_idx, wr_idx;
    logic [WORD_W-1:0] wr_data;
    logic              load_out;

    div_req_t dreq;
    div_rsp_t drsp;

    logic              accept;
    logic [IP_W-1:0]   ip;
    logic              oob;
    logic [IDX_W-1:0]  nm1;
    logic [DVSR_W-1:0] m_val;
    logic [WORD_W-1:0] md;

    assign accept = in_valid && !in_stall;
    assign ip     = x_value[X_W-1:FRAC_W];
    assign oob    = (ip == '0) || ({1'b0, ip} > (IP_W + 1)'(MAX_LINES));
    assign m_val  = DVSR_W'(brow_reg) + DVSR_W'(2);

    always_comb
    begin
        if (num_coeffs_reg == '0)
            nm1 = '0;
        else if (32'(num_coeffs_reg) > 32'(MAX_COEFFS))
            nm1 = IDX_W'(MAX_COEFFS - 1);
        else
            nm1 = IDX_W'(num_coeffs_reg - CFG_W'(1));
    end

    assign rd_val = rd_base_reg ? rd_const_reg : rd_data_reg;
    assign md     = 64'({phi_reg, 8'b0}) + 64'(plo_reg >> FRAC_W);

    drho_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (oob)
                        state_next = S_DONE;
                    else if ({1'b0, rows_built_reg} <= (RB_W + 1)'(ip - IP_W'(1)))
                        state_next = S_BROW;
                    else
                        state_next = S_ERD;
                end
            end
            S_BROW:  state_next = (nm1 == '0) ? S_B0S : S_BJ;
            S_BJ:    state_next = S_BRD;
            S_BRD:   state_next = S_BWAIT;
            S_BWAIT: state_next = S_BDMS;
            S_BDMS:  state_next = S_BDMW;
            S_BDMW:
            begin
                if (drsp.done)
                    state_next = (p_reg == IDX_W'(1)) ? S_BDJS : S_BDMS;
            end
            S_BDJS:  state_next = S_BDJW;
            S_BDJW:
            begin
                if (drsp.done)
                    state_next = (k_reg == j_reg - IDX_W'(1)) ? S_BWRJ : S_BRD;
            end
            S_BWRJ:  state_next = S_BHW;
            S_BHW:
            begin
                if (drsp.done)
                    state_next = (j_reg == nm1) ? S_B0S : S_BJ;
            end
            S_B0S:   state_next = S_B0W;
            S_B0W:
            begin
                if (drsp.done)
                    state_next = (brow_reg == row_reg) ? S_ERD : S_BROW;
            end
            S_ERD:   state_next = S_EW;
            S_EW:    state_next = (i_reg == '0) ? S_DONE : S_EM1;
            S_EM1:   state_next = S_EM2;
            S_EM2:   state_next = S_EADD;
            S_EADD:  state_next = (i_reg == IDX_W'(1)) ? S_DONE : S_EM1;
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // controller outputs
    always_comb
    begin
        rd_en         = 1'b0;
        rd_row        = row_reg;
        rd_idx        = '0;
        wr_en         = 1'b0;
        wr_idx        = '0;
        wr_data       = c_reg;
        load_out      = 1'b0;
        dreq.start    = 1'b0;
        dreq.dividend = t_reg;
        dreq.divisor  = m_val;
        case (state_reg)
            S_BRD:
            begin
                rd_en  = 1'b1;
                rd_row = brow_reg - ROW_W'(1);
                rd_idx = k_reg;
            end
            S_BDMS:
            begin
                dreq.start = 1'b1;
            end
            S_BDJS:
            begin
                dreq.start   = 1'b1;
                dreq.divisor = DVSR_W'(j_reg);
            end
            S_BWRJ:
            begin
                wr_en         = 1'b1;
                wr_idx        = j_reg;
                dreq.start    = 1'b1;
                dreq.dividend = c_reg;
                dreq.divisor  = DVSR_W'(j_reg) + DVSR_W'(1);
            end
            S_B0S:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = head_reg;
                dreq.divisor  = m_val - DVSR_W'(1);
            end
            S_B0W:
            begin
                wr_en   = drsp.done;
                wr_data = drsp.quotient;
            end
            S_ERD:
            begin
                rd_en  = 1'b1;
                rd_idx = nm1;
            end
            S_EW:
            begin
                rd_en  = (i_reg != '0);
                rd_idx = i_reg - IDX_W'(1);
            end
            S_EADD:
            begin
                rd_en  = (i_reg != IDX_W'(1));
                rd_idx = i_reg - IDX_W'(2);
            end
            S_DONE:
            begin
                load_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[{brow_reg, wr_idx}] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= mem[{rd_row, rd_idx}];
            rd_const_reg <= ROW0[5'(rd_idx)];
            rd_base_reg  <= (rd_row == '0);
        end
    end

    assign out_valid_next = (out_valid_reg && out_stall) || load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            num_coeffs_reg <= CFG_W'(24);
            rows_built_reg <= RB_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                num_coeffs_reg <= cfg_wr_data;
                rows_built_reg <= RB_W'(1);
            end
            else if (state_reg == S_B0W && drsp.done)
                rows_built_reg <= rows_built_reg + RB_W'(1);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    err_reg  <= oob;
                    acc_reg  <= '0;
                    d_reg    <= D_W'(1 << FRAC_W) - {1'b0, x_value[FRAC_W-1:0]};
                    row_reg  <= ROW_W'(ip - IP_W'(1));
                    brow_reg <= ROW_W'(rows_built_reg);
                end
            end
            S_BROW:
            begin
                j_reg    <= IDX_W'(1);
                head_reg <= '0;
            end
            S_BJ:
            begin
                c_reg <= '0;
                k_reg <= '0;
            end
            S_BWAIT:
            begin
                t_reg <= rd_val;
                p_reg <= j_reg - k_reg;
            end
            S_BDMW:
            begin
                if (drsp.done)
                begin
                    t_reg <= drsp.quotient;
                    p_reg <= p_reg - IDX_W'(1);
                end
            end
            S_BDJW:
            begin
                if (drsp.done)
                begin
                    c_reg <= sat_add(c_reg, drsp.quotient);
                    k_reg <= k_reg + IDX_W'(1);
                end
            end
            S_BHW:
            begin
                if (drsp.done)
                begin
                    head_reg <= sat_add(head_reg, drsp.quotient);
                    j_reg    <= j_reg + IDX_W'(1);
                end
            end
            S_B0W:
            begin
                if (drsp.done)
                    brow_reg <= brow_reg + ROW_W'(1);
            end
            S_ERD:
            begin
                i_reg <= nm1;
            end
            S_EW:
            begin
                acc_reg <= rd_val;
            end
            S_EM1:
            begin
                phi_reg <= P_W'(acc_reg[WORD_W-1:32]) * P_W'(d_reg);
            end
            S_EM2:
            begin
                plo_reg <= P_W'(acc_reg[31:0]) * P_W'(d_reg);
            end
            S_EADD:
            begin
                acc_reg <= sat_add(rd_val, md);
                i_reg   <= i_reg - IDX_W'(1);
            end
            default:
            begin
                err_reg <= err_reg;
            end
        endcase
        if (load_out)
        begin
            rho_reg    <= acc_reg;
            status_reg <= err_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign rho_value = rho_reg;
    assign status    = status_reg;

`ifndef SYNTH
    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rows_built_reg <= RB_W'(MAX_LINES))
        else $error("rows_built beyond table");

    a_row_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ERD |-> {1'b0, rows_built_reg} > (RB_W + 1)'(row_reg))
        else $error("evaluation of unbuilt row");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> rho_value == '0)
        else $error("out of range item with nonzero value");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == S_BDMW || state_reg == S_BDJW ||
                       state_reg == S_BHW || state_reg == S_B0W))
        else $error("divider finished outside a wait state");

    a_build_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BROW |-> brow_reg != '0)
        else $error("attempt to rebuild base row");
`endif

endmodule

@@ rtl/core/drho_div.sv @@
// bit-serial restoring divider, 64-bit dividend by a small divisor
// uses drho_pkg
module drho_div
    import drho_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [WORD_W-1:0] quo_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[WORD_W-1]};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                // zero dividend finishes at once
                busy_reg <= (req.dividend != '0);
                done_reg <= (req.dividend == '0);
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg  <= req.dividend;
            rem_reg  <= '0;
            dvsr_reg <= req.divisor;
            cnt_reg  <= CNT_W'(WORD_W - 1);
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[WORD_W-2:0], fits};
            rem_reg <= fits ? REM_W'(trial - {1'b0, dvsr_reg}) : REM_W'(trial);
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ test/dickman_rho_evaluator_tb.sv @@
// testbench for dickman_rho_evaluator: random and edge-case x values across num_coeffs settings
// results are checked against an in-bench model of the lazily built coefficient table
// depends on drho_pkg and the dickman_rho_evaluator rtl
`timescale 1ns / 1ps

module dickman_rho_evaluator_tb;
    import drho_pkg::*;

    localparam int LINES   = 8;
    localparam int COEFFS  = 24;
    localparam int WD_LIMIT = 700000;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [X_W-1:0]    x_value;
    logic              out_valid;
    logic              out_stall;
    logic [WORD_W-1:0] rho_value;
    logic              status;

    logic [X_W-1:0]    pending_x [$];
    logic [WORD_W-1:0] exp_rho [$];
    logic              exp_status [$];

    logic [WORD_W-1:0] coeff_tab [LINES][COEFFS];
    int unsigned       rows_valid;
    int unsigned       coeff_cfg;

    int  errors;
    int  items_sent;
    int  results_seen;
    int  out_of_range_seen;
    int  tx_gap;
    int  rx_gap;
    int  quiet_cycles;
    bit  calm;

    dickman_rho_evaluator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .x_value     (x_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rho_value   (rho_value),
        .status      (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [WORD_W-1:0] add_clip(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? '1 : s[WORD_W-1:0];
    endfunction

    function automatic int unsigned used_coeffs();
        int unsigned n;
        n = coeff_cfg;
        if (n < 1)
            n = 1;
        if (n > COEFFS)
            n = COEFFS;
        return n;
    endfunction

    task automatic seed_table();
        coeff_tab[0][0] = 64'h4E8DE8082E308654;
        for (int i = 1; i < COEFFS; i++)
            coeff_tab[0][i] = (64'd1 << (64 - i)) / 64'(i);
        rows_valid = 1;
    endtask

    task automatic extend_row(input int unsigned r);
        int unsigned       n;
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] head;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] t;
        n = used_coeffs();
        m = 64'(r + 2);
        head = '0;
        for (int j = 1; j < n; j++)
        begin
            c = '0;
            for (int k = 0; k < j; k++)
            begin
                t = coeff_tab[r-1][k];
                for (int p = 0; p < j - k; p++)
                    t = t / m;
                t = t / 64'(j);
                c = add_clip(c, t);
            end
            coeff_tab[r][j] = c;
            head = add_clip(head, c / 64'(j + 1));
        end
        coeff_tab[r][0] = head / (m - 64'd1);
    endtask

    task automatic rho_predict(input logic [X_W-1:0] x);
        int unsigned       ip;
        int unsigned       row;
        int unsigned       n;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
        ip = 32'(x[X_W-1:FRAC_W]);
        if (ip < 1 || ip > LINES)
        begin
            exp_rho.push_back('0);
            exp_status.push_back(1'b1);
            return;
        end
        row = ip - 1;
        while (rows_valid <= row)
        begin
            extend_row(rows_valid);
            rows_valid++;
        end
        n = used_coeffs();
        d = (64'd1 << FRAC_W) - 64'(x[FRAC_W-1:0]);
        acc = coeff_tab[row][n-1];
        for (int i = n - 1; i > 0; i--)
        begin
            hi = acc >> 32;
            lo = acc & 64'hFFFFFFFF;
            acc = add_clip(coeff_tab[row][i-1], ((hi * d) << 8) + ((lo * d) >> FRAC_W));
        end
        exp_rho.push_back(acc);
        exp_status.push_back(1'b0);
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        $display("mismatch %s: expected %h got %h (result %0d)", what, want, got,
                 results_seen);
        errors++;
    endtask

    function automatic logic [X_W-1:0] pick_x(input int unsigned top_ip);
        logic [FRAC_W-1:0] f;
        int unsigned       ip;
        case ($urandom_range(0, 7))
            0: f = '0;
            1: f = '1;
            2: f = FRAC_W'($urandom_range(0, 15));
            default: f = FRAC_W'($urandom);
        endcase
        ip = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, top_ip);
        return {IP_W'(ip), f};
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            x_value  <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                rho_predict(x_value);
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_x.size() > 0 && !calm && $urandom_range(0, 5) == 0)
                begin
                    tx_gap   <= $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end
                else if (pending_x.size() > 0)
                begin
                    in_valid <= 1'b1;
                    x_value  <= pending_x.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver, checker and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            rx_gap       <= 0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (exp_rho.size() == 0)
                begin
                    $display("unexpected result rho %h status %b", rho_value, status);
                    errors++;
                end
                else
                begin
                    if (status)
                        out_of_range_seen++;
                    if (status !== exp_status[0])
                        report_mismatch("status", WORD_W'(exp_status[0]), WORD_W'(status));
                    if (rho_value !== exp_rho[0])
                        report_mismatch("rho_value", exp_rho[0], rho_value);
                    void'(exp_rho.pop_front());
                    void'(exp_status.pop_front());
                end
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WD_LIMIT)
            begin
                $display("watchdog: no progress, %0d results pending", exp_rho.size());
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
            if (rx_gap > 0)
            begin
                rx_gap    <= rx_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rx_gap    <= $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_x.size() > 0 || in_valid || exp_rho.size() > 0);
    endtask

    task automatic write_coeffs(input int unsigned n);
        wait_drained();
        repeat (20) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(n);
        coeff_cfg  = n;
        rows_valid = 1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned top_ip, input int unsigned count);
        for (int i = 0; i < count; i++)
        begin
            pending_x.push_back(pick_x(top_ip));
            if (i == count / 2)
                wait_drained();
        end
    endtask

    int unsigned small_n [7] = '{2, 5, 1, 0, 8, 3, 6};

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        out_of_range_seen = 0;
        calm = 1'b0;
        coeff_cfg = 24;
        seed_table();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting, large rows are slow so stay in the first two intervals
        run_phase(2, 120);

        write_coeffs(4);
        pending_x.push_back('0);
        pending_x.push_back(X_W'(1) << FRAC_W);
        pending_x.push_back((X_W'(1) << FRAC_W) - X_W'(1));
        pending_x.push_back((X_W'(1) << FRAC_W) + X_W'(1));
        pending_x.push_back(X_W'(150994943));
        pending_x.push_back({4'd8, 24'd0});
        pending_x.push_back({4'd8, 24'h000001});
        for (int ip = 7; ip >= 1; ip--)
        begin
            pending_x.push_back({IP_W'(ip), 24'd0});
            pending_x.push_back({IP_W'(ip), 24'hFFFFFF});
        end
        pending_x.push_back({4'd3, 24'h800000});
        pending_x.push_back({4'd0, 24'hFFFFFF});
        run_phase(8, 180);

        foreach (small_n[i])
        begin
            write_coeffs(small_n[i]);
            run_phase(8, 180);
        end

        // a register value above 24 clamps to the full row width
        write_coeffs(30);
        run_phase(2, 100);

        write_coeffs(7);
        calm = 1'b1;
        run_phase(8, 150);

        wait_drained();
        repeat (100) @(posedge clk);
        $display("covered %0d items over 11 num_coeffs settings, %0d results checked",
                 items_sent, results_seen);
        $display("out-of-range results: %0d, mismatches: %0d", out_of_range_seen, errors);
        if (errors == 0 && exp_rho.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
